// ----- sv/gji_pkg.sv -----
// shared constants for the gauss-jordan inverse unit
`timescale 1ns / 1ps
package gji_pkg;
   localparam int DATA_W        = 32;
   localparam int SIZE_W        = 4;
   localparam int DEF_MAX_DIM   = 8;
   localparam int DEF_FRAC_BITS = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   // register index (address bit 2)
   localparam logic REG_MATRIX_SIZE = 1'b0;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
endpackage

// ----- sv/gji_req_if.sv -----
// input item channel of the gauss-jordan inverse unit
`timescale 1ns / 1ps
interface gji_req_if import gji_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] element_value;
   logic                     element_last;
   modport source (output valid, element_value, element_last, input ready);
   modport sink   (input valid, element_value, element_last, output ready);
endinterface

// ----- sv/gji_rsp_if.sv -----
// result item channel of the gauss-jordan inverse unit
`timescale 1ns / 1ps
interface gji_rsp_if import gji_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic                     singular;
   logic                     overflow;
   logic                     result_last;
   modport source (output valid, result_value, singular, overflow, result_last, input ready);
   modport sink   (input valid, result_value, singular, overflow, result_last, output ready);
endinterface

// ----- sv/gauss_jordan_matrix_inverse_unit.sv -----
// top level: gauss-jordan matrix inverse over a store with one read and one write port
`timescale 1ns / 1ps
//
// channel  direction  payload                                       accepted when
// req      in         element_value, element_last                   req.valid & req.ready
// rsp      out        result_value, singular, overflow, result_last rsp.valid & rsp.ready
// csr      in         matrix_size at byte address 0                 psel & penable & pwrite
//
// items are loaded while idle; the marked item starts zero fill and identity build,
// then elimination through the store's one read port: each pivot row element goes
// through the bit serial divider or is kept as it is on a unit pivot, and each
// updated element is read, multiplied, rounded and subtracted; each result waits
// out any rsp stall in OUT_HOLD. reset is synchronous.
// no item is accepted from the marked item until its last result is taken.
//
module gauss_jordan_matrix_inverse_unit import gji_pkg::*; #(
   parameter int MAX_DIM   = DEF_MAX_DIM,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   gji_req_if.sink               req,
   gji_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   localparam int ROW_STRIDE = 2 * MAX_DIM;
   localparam int DEPTH      = MAX_DIM * ROW_STRIDE;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int RW         = $clog2(MAX_DIM + 1);
   localparam int COL_W      = $clog2(ROW_STRIDE + 1);
   localparam int PB_W       = $clog2(ROW_STRIDE);
   localparam int NUM_W      = DATA_W + FRAC_BITS;
   localparam int DCNT_W     = $clog2(NUM_W + 1);
   localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);
   localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
   localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

   typedef enum logic [4:0] {
      IDLE, FILL_L, FILL_R, PIV_RD, PIV_WT, ROWP_RD, ROWP_WT, DIV, DIV_FIN, PIV_SET,
      KSEL, T_WT, E_RD, E_WT, E_RND, E_SUB, E_ZERO, OUT_RD, OUT_WT, OUT_HOLD
   } state_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [RW-1:0] row,
                                                 input logic [COL_W-1:0] col);
      return ADDR_W'(int'(row) * ROW_STRIDE + int'(col));
   endfunction

   function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
   endfunction

   // augmented matrix store, one row every ROW_STRIDE words
   logic [DATA_W-1:0] store_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   state_type state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [RW-1:0]     load_row_ff, load_row_in, load_col_ff, load_col_in;
   logic [RW-1:0]     i_ff, i_in, k_ff, k_in, r_ff, r_in, c_ff, c_in;
   logic [COL_W-1:0]  j_ff, j_in;
   logic [DATA_W-1:0] piv_ff, piv_in, t_ff, t_in, rowv_ff, rowv_in, den_ff, den_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              dneg_ff, dneg_in, mneg_ff, mneg_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0]       mag_ff, mag_in;
   logic              sing_ff, sing_in, ovf_ff, ovf_in;
   logic [DATA_W-1:0] out_val_ff, out_val_in;
   logic              out_sing_ff, out_sing_in, out_ovf_ff, out_ovf_in;
   logic              out_last_ff, out_last_in, out_valid_ff, out_valid_in;
   // copy of the current pivot row, read one column at a time
   logic [DATA_W-1:0] prow_ff [ROW_STRIDE];
   logic [DATA_W-1:0] prow_in [ROW_STRIDE];

   // effective size: zero acts as one, too large acts as the maximum
   logic [RW-1:0]    n;
   logic [COL_W-1:0] w;
   always_comb begin
      if (size_ff == '0) begin
         n = RW'(1);
      end else if (size_ff > SIZE_W'(MAX_DIM)) begin
         n = RW'(MAX_DIM);
      end else begin
         n = RW'(size_ff);
      end
      w = COL_W'(n) << 1;
   end

   logic cfg_wr;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & (csr_paddr[2] == REG_MATRIX_SIZE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MATRIX_SIZE) ? CSR_DATA_W'(size_ff) : '0;

   logic              accept;
   assign accept = req.valid & req.ready;

   // datapath scratch
   logic [DATA_W:0]    trial;
   logic               qbit;
   logic [63:0]        absp;
   logic signed [64:0] diff, rowx, magx;
   logic [DATA_W-1:0]  ua, up;

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      load_row_in  = load_row_ff;
      load_col_in  = load_col_ff;
      i_in = i_ff; k_in = k_ff; r_in = r_ff; c_in = c_ff; j_in = j_ff;
      piv_in = piv_ff; t_in = t_ff; rowv_in = rowv_ff; den_in = den_ff;
      rem_in = rem_ff; quo_in = quo_ff; dcnt_in = dcnt_ff;
      dneg_in = dneg_ff; mneg_in = mneg_ff; prod_in = prod_ff; mag_in = mag_ff;
      sing_in = sing_ff; ovf_in = ovf_ff;
      out_val_in = out_val_ff; out_sing_in = out_sing_ff; out_ovf_in = out_ovf_ff;
      out_last_in = out_last_ff; out_valid_in = out_valid_ff;
      prow_in = prow_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = '0;
      trial = {rem_ff, quo_ff[NUM_W-1]};
      qbit  = trial >= {1'b0, den_ff};
      absp  = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
      rowx  = 65'(signed'(rowv_ff));
      magx  = signed'({1'b0, mag_ff});
      diff  = mneg_ff ? rowx + magx : rowx - magx;
      ua    = mag32(rd_data_ff);
      up    = mag32(piv_ff);

      if (cfg_wr) begin
         size_in     = csr_pwdata[SIZE_W-1:0];
         load_row_in = '0;
         load_col_in = '0;
      end

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               if (load_row_ff < n) begin
                  wr_en   = 1'b1;
                  wr_addr = addr_of(load_row_ff, COL_W'(load_col_ff));
                  wr_data = req.element_value;
                  if (load_col_ff == n - RW'(1)) begin
                     load_col_in = '0;
                     load_row_in = load_row_ff + RW'(1);
                  end else begin
                     load_col_in = load_col_ff + RW'(1);
                  end
               end
               if (req.element_last) begin
                  state_in = FILL_L;
               end
            end
         end
         // zero the elements the early mark left out
         FILL_L: begin
            if (load_row_ff < n) begin
               wr_en   = 1'b1;
               wr_addr = addr_of(load_row_ff, COL_W'(load_col_ff));
               if (load_col_ff == n - RW'(1)) begin
                  load_col_in = '0;
                  load_row_in = load_row_ff + RW'(1);
               end else begin
                  load_col_in = load_col_ff + RW'(1);
               end
            end else begin
               r_in = '0; c_in = '0;
               state_in = FILL_R;
            end
         end
         // identity in the right half
         FILL_R: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(r_ff, COL_W'(n) + COL_W'(c_ff));
            wr_data = (r_ff == c_ff) ? FX_ONE : '0;
            if (c_ff == n - RW'(1)) begin
               c_in = '0;
               r_in = r_ff + RW'(1);
               if (r_ff == n - RW'(1)) begin
                  sing_in  = 1'b0;
                  ovf_in   = 1'b0;
                  i_in     = '0;
                  state_in = PIV_RD;
               end
            end else begin
               c_in = c_ff + RW'(1);
            end
         end
         PIV_RD: begin
            rd_addr  = addr_of(i_ff, COL_W'(i_ff));
            state_in = PIV_WT;
         end
         PIV_WT: begin
            piv_in = rd_data_ff;
            if (rd_data_ff == '0) begin
               sing_in  = 1'b1;
               r_in = '0; c_in = '0;
               state_in = OUT_RD;
            end else begin
               j_in = COL_W'(i_ff) + COL_W'(1);
               state_in = ROWP_RD;
            end
         end
         ROWP_RD: begin
            rd_addr  = addr_of(i_ff, j_ff);
            state_in = ROWP_WT;
         end
         ROWP_WT: begin
            if (piv_ff == FX_ONE) begin
               prow_in[j_ff[PB_W-1:0]] = rd_data_ff;
               j_in = j_ff + COL_W'(1);
               state_in = (j_ff + COL_W'(1) == w) ? PIV_SET : ROWP_RD;
            end else begin
               quo_in  = (NUM_W'(ua) << FRAC_BITS) + NUM_W'(up >> 1);
               rem_in  = '0;
               den_in  = up;
               dneg_in = rd_data_ff[DATA_W-1] ^ piv_ff[DATA_W-1];
               dcnt_in = '0;
               state_in = DIV;
            end
         end
         // restoring divider, one quotient bit per cycle
         DIV: begin
            rem_in  = qbit ? DATA_W'(trial - {1'b0, den_ff}) : DATA_W'(trial);
            quo_in  = {quo_ff[NUM_W-2:0], qbit};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(NUM_W - 1)) begin
               state_in = DIV_FIN;
            end
         end
         DIV_FIN: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(i_ff, j_ff);
            if (!dneg_ff && quo_ff > NUM_W'(64'h7FFF_FFFF)) begin
               wr_data = 32'h7FFF_FFFF;
               ovf_in  = 1'b1;
            end else if (dneg_ff && quo_ff > NUM_W'(64'h8000_0000)) begin
               wr_data = 32'h8000_0000;
               ovf_in  = 1'b1;
            end else begin
               wr_data = dneg_ff ? (~quo_ff[DATA_W-1:0] + DATA_W'(1)) : quo_ff[DATA_W-1:0];
            end
            prow_in[j_ff[PB_W-1:0]] = wr_data;
            j_in = j_ff + COL_W'(1);
            state_in = (j_ff + COL_W'(1) == w) ? PIV_SET : ROWP_RD;
         end
         PIV_SET: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(i_ff, COL_W'(i_ff));
            wr_data = FX_ONE;
            k_in    = '0;
            state_in = KSEL;
         end
         // pick the next row to clear in the pivot column
         KSEL: begin
            if (k_ff == n) begin
               i_in = i_ff + RW'(1);
               if (i_ff + RW'(1) == n) begin
                  r_in = '0; c_in = '0;
                  state_in = OUT_RD;
               end else begin
                  state_in = PIV_RD;
               end
            end else if (k_ff == i_ff) begin
               k_in = k_ff + RW'(1);
            end else begin
               rd_addr  = addr_of(k_ff, COL_W'(i_ff));
               state_in = T_WT;
            end
         end
         T_WT: begin
            t_in = rd_data_ff;
            if (rd_data_ff == '0) begin
               k_in = k_ff + RW'(1);
               state_in = KSEL;
            end else begin
               j_in = COL_W'(i_ff) + COL_W'(1);
               state_in = E_RD;
            end
         end
         E_RD: begin
            rd_addr  = addr_of(k_ff, j_ff);
            state_in = E_WT;
         end
         E_WT: begin
            rowv_in = rd_data_ff;
            prod_in = signed'(t_ff) * signed'(prow_ff[j_ff[PB_W-1:0]]);
            state_in = E_RND;
         end
         // round the product magnitude, ties away from zero
         E_RND: begin
            mag_in  = (absp + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            mneg_in = prod_ff[63];
            state_in = E_SUB;
         end
         E_SUB: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(k_ff, j_ff);
            if (diff > SAT_HI) begin
               wr_data = 32'h7FFF_FFFF;
               ovf_in  = 1'b1;
            end else if (diff < SAT_LO) begin
               wr_data = 32'h8000_0000;
               ovf_in  = 1'b1;
            end else begin
               wr_data = diff[DATA_W-1:0];
            end
            j_in = j_ff + COL_W'(1);
            state_in = (j_ff + COL_W'(1) == w) ? E_ZERO : E_RD;
         end
         E_ZERO: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(k_ff, COL_W'(i_ff));
            k_in    = k_ff + RW'(1);
            state_in = KSEL;
         end
         OUT_RD: begin
            rd_addr  = addr_of(r_ff, COL_W'(n) + COL_W'(c_ff));
            state_in = OUT_WT;
         end
         OUT_WT: begin
            out_val_in   = sing_ff ? '0 : rd_data_ff;
            out_sing_in  = sing_ff;
            out_ovf_in   = ovf_ff;
            out_last_in  = (r_ff == n - RW'(1)) && (c_ff == n - RW'(1));
            out_valid_in = 1'b1;
            state_in     = OUT_HOLD;
         end
         OUT_HOLD: begin
            if (rsp.ready) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  load_row_in = '0;
                  load_col_in = '0;
                  state_in    = IDLE;
               end else begin
                  if (c_ff == n - RW'(1)) begin
                     c_in = '0;
                     r_in = r_ff + RW'(1);
                  end else begin
                     c_in = c_ff + RW'(1);
                  end
                  state_in = OUT_RD;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         size_ff      <= SIZE_RESET;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         sing_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         sing_ff      <= sing_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
      i_ff <= i_in; k_ff <= k_in; r_ff <= r_in; c_ff <= c_in; j_ff <= j_in;
      piv_ff <= piv_in; t_ff <= t_in; rowv_ff <= rowv_in; den_ff <= den_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dcnt_ff <= dcnt_in;
      dneg_ff <= dneg_in; mneg_ff <= mneg_in; prod_ff <= prod_in; mag_ff <= mag_in;
      out_val_ff <= out_val_in; out_sing_ff <= out_sing_in; out_ovf_ff <= out_ovf_in;
      out_last_ff <= out_last_in;
      prow_ff <= prow_in;
   end

   assign req.ready        = (state_ff == IDLE);
   assign rsp.valid        = out_valid_ff;
   assign rsp.result_value = out_val_ff;
   assign rsp.singular     = out_sing_ff;
   assign rsp.overflow     = out_ovf_ff;
   assign rsp.result_last  = out_last_ff;

`ifndef SYNTH
   // no item taken while a result is pending
   a_no_load_during_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("item accepted with result pending");
   // a singular matrix gives zero results
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.singular) |-> (rsp.result_value == '0))
      else $error("nonzero result on singular matrix");
   // after the last result the unit takes items again
   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.result_last) |=> req.ready)
      else $error("not ready after last result");
   // store writes stay inside the store
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (int'(wr_addr) < DEPTH)) else $error("store write out of range");
`endif

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the gauss-jordan matrix inverse unit
`timescale 1ns / 1ps
module tb;
   import gji_pkg::*;

   localparam int ONE_FX = 1 << DEF_FRAC_BITS;
   localparam int STRIDE = 2 * DEF_MAX_DIM;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SIZE   = {REG_MATRIX_SIZE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED = 3'd4;
   localparam int SETTLE = 40;

   typedef enum {MX_DOMINANT, MX_RANDOM, MX_IDENTITY, MX_ZERO_PIVOT,
                 MX_SHORT, MX_LONG, MX_HUGE} mx_kind_type;

   typedef struct {
      logic [DATA_W-1:0] value;
      bit                singular;
      bit                overflow;
      bit                last;
   } inv_elem_type;

   // predicts the inverse from accepted elements and checks the results
   class inverse_scoreboard;
      int              grid [DEF_MAX_DIM*STRIDE];
      int unsigned     loaded;
      bit [1:0]        flags;
      bit [SIZE_W-1:0] size_reg;
      inv_elem_type    inverse_q [$];
      int              errors;

      function new();
         foreach (grid[i]) grid[i] = 0;
         loaded   = 0;
         flags    = 0;
         size_reg = SIZE_RESET;
         errors   = 0;
      endfunction

      function int dim();
         if (size_reg == 0) return 1;
         if (size_reg > DEF_MAX_DIM) return DEF_MAX_DIM;
         return size_reg;
      endfunction

      function void set_size(bit [SIZE_W-1:0] v);
         size_reg = v;
         loaded   = 0;
      endfunction

      function int pending();
         return inverse_q.size();
      endfunction

      function int clip(longint v);
         if (v > 64'sd2147483647) begin
            flags[1] = 1;
            return 32'sh7fffffff;
         end
         if (v < -64'sd2147483648) begin
            flags[1] = 1;
            return 32'sh80000000;
         end
         return int'(v);
      endfunction

      function int fx_div(int a, int p);
         longint ua, up, q;
         ua = (a < 0) ? -longint'(a) : longint'(a);
         up = (p < 0) ? -longint'(p) : longint'(p);
         q  = ((ua << DEF_FRAC_BITS) + up / 2) / up;
         return clip(((a < 0) != (p < 0)) ? -q : q);
      endfunction

      function longint fx_mul(int a, int b);
         longint prod, m;
         prod = longint'(a) * longint'(b);
         m    = (prod < 0) ? -prod : prod;
         m    = (m + (64'sd1 << (DEF_FRAC_BITS - 1))) >>> DEF_FRAC_BITS;
         return (prod < 0) ? -m : m;
      endfunction

      function void eliminate(int n);
         int p, t;
         for (int i = 0; i < n; i++) begin
            p = grid[i*STRIDE+i];
            if (p == 0) begin
               flags[0] = 1;
               return;
            end
            // a unit pivot leaves its row as it is
            if (p != ONE_FX)
               for (int j = i + 1; j < 2 * n; j++)
                  grid[i*STRIDE+j] = fx_div(grid[i*STRIDE+j], p);
            grid[i*STRIDE+i] = ONE_FX;
            for (int k = 0; k < n; k++) begin
               if (k == i) continue;
               t = grid[k*STRIDE+i];
               if (t == 0) continue;
               for (int j = i + 1; j < 2 * n; j++)
                  grid[k*STRIDE+j] = clip(longint'(grid[k*STRIDE+j])
                                          - fx_mul(t, grid[i*STRIDE+j]));
               grid[k*STRIDE+i] = 0;
            end
         end
      endfunction

      function void note_element(logic [DATA_W-1:0] v, bit last);
         int n, total;
         inv_elem_type e;
         n = dim();
         total = n * n;
         if (loaded < total) begin
            grid[(loaded / n) * STRIDE + loaded % n] = int'(v);
            loaded++;
         end
         if (!last) return;
         for (int pos = loaded; pos < total; pos++)
            grid[(pos / n) * STRIDE + pos % n] = 0;
         for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
               grid[r*STRIDE+n+c] = (r == c) ? ONE_FX : 0;
         flags = 0;
         eliminate(n);
         for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
               e.value    = flags[0] ? '0 : grid[r*STRIDE+n+c];
               e.singular = flags[0];
               e.overflow = flags[1];
               e.last     = (r == n - 1) && (c == n - 1);
               inverse_q.push_back(e);
            end
         loaded = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("tb: mismatch: %s", msg);
      endtask

      task check_result(logic [DATA_W-1:0] v, logic sing, logic ovf, logic last);
         inv_elem_type e;
         if (inverse_q.size() == 0) begin
            report("result with none expected");
            return;
         end
         e = inverse_q.pop_front();
         if (v !== e.value || sing !== e.singular || ovf !== e.overflow
             || last !== e.last)
            report($sformatf("got %h s%b o%b l%b, want %h s%b o%b l%b",
                             v, sing, ovf, last, e.value, e.singular,
                             e.overflow, e.last));
      endtask
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   gji_req_if req_if ();
   gji_rsp_if rsp_if ();

   inverse_scoreboard sb = new();
   int  items_sent = 0;
   bit  quiet = 0;   // no idling on either side in the closing part

   gauss_jordan_matrix_inverse_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   initial begin
      req_if.valid = 0;
      req_if.element_value = '0;
      req_if.element_last = 0;
      rsp_if.ready = 0;
   end

   // watchdog
   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

   // result side: random stall bursts, ready held high otherwise
   initial begin
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_if.ready = 0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_if.ready = 1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.result_value, rsp_if.singular, rsp_if.overflow,
                         rsp_if.result_last);

   // one element item; valid stays up into the next item unless a gap is drawn
   task send_element(logic [DATA_W-1:0] v, bit last);
      @(negedge clock);
      req_if.valid = 1;
      req_if.element_value = v;
      req_if.element_last = last;
      do @(posedge clock); while (!req_if.ready);
      sb.note_element(v, last);
      items_sent++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_if.valid = 0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
   endtask

   // drop valid, let every expected result drain and the block settle
   task wait_idle();
      @(negedge clock);
      req_if.valid = 0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_SIZE) sb.set_size(data[SIZE_W-1:0]);
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   task csr_check_size();
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 0;
      csr_penable = 0;
      csr_paddr = ADDR_SIZE;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[SIZE_W-1:0] !== sb.size_reg)
         sb.report($sformatf("matrix_size read %h, want %h", csr_prdata, sb.size_reg));
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
   endtask

   task set_size(int v);
      wait_idle();
      csr_write(ADDR_SIZE, {$urandom} & ~32'hF | v);
      csr_check_size();
   endtask

   function logic [DATA_W-1:0] near_unit();
      return $signed($urandom_range(0, 2 * ONE_FX)) - ONE_FX;
   endfunction

   task run_matrix(mx_kind_type kind);
      int n, total, count, r, c, mag;
      logic [DATA_W-1:0] v;
      n = sb.dim();
      total = n * n;
      count = (kind == MX_SHORT) ? $urandom_range(1, total) :
              (kind == MX_LONG)  ? total + $urandom_range(1, 3) : total;
      for (int idx = 0; idx < count; idx++) begin
         r = (idx / n) % n;
         c = idx % n;
         case (kind)
            MX_RANDOM:   v = $urandom;
            MX_IDENTITY: v = (r == c) ? ONE_FX : 0;
            MX_HUGE: begin
               // tiny pivots against wide elements drive saturation
               v = (r == c) ? $urandom_range(1, 64) : $urandom;
            end
            default: begin
               mag = $urandom_range((n + 1) * ONE_FX, 4 * (n + 1) * ONE_FX);
               v = (r == c) ? ($urandom_range(0, 1) ? -mag : mag) : near_unit();
            end
         endcase
         if (kind == MX_ZERO_PIVOT && idx == 0) v = 0;
         send_element(v, idx == count - 1);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // single elements: extremes, unit and zero pivots
      set_size(1);
      send_element(32'h8000_0000, 1);
      send_element(32'h7fff_ffff, 1);
      send_element(32'h0000_0000, 1);
      send_element(ONE_FX, 1);
      send_element(-ONE_FX, 1);
      send_element(32'h0000_0001, 1);
      send_element(32'hffff_ffff, 1);
      // surplus elements up to and including the mark are dropped
      send_element(2 * ONE_FX, 0);
      send_element(32'h1234_5678, 1);

      set_size(2);
      run_matrix(MX_IDENTITY);
      run_matrix(MX_ZERO_PIVOT);
      run_matrix(MX_SHORT);
      run_matrix(MX_HUGE);
      // a partial load is discarded by a size write
      send_element(3 * ONE_FX, 0);
      send_element(ONE_FX, 0);
      wait_idle();
      csr_write(ADDR_UNUSED, 32'hffff_ffff);
      csr_check_size();
      set_size(3);
      run_matrix(MX_DOMINANT);
      set_size(0);       // acts as one
      run_matrix(MX_DOMINANT);
      set_size(15);      // acts as the largest size
      run_matrix(MX_DOMINANT);

      // random part, mostly small well-conditioned matrices
      while (items_sent < 150) begin
         if (items_sent > 110) quiet = 1;
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 9) == 0) set_size($urandom_range(5, 8));
            else set_size($urandom_range(1, 4));
         end
         case ($urandom_range(0, 11))
            0:       run_matrix(MX_RANDOM);
            1:       run_matrix(MX_IDENTITY);
            2:       run_matrix(MX_ZERO_PIVOT);
            3:       run_matrix(MX_SHORT);
            4:       run_matrix(MX_LONG);
            5:       run_matrix(MX_HUGE);
            default: run_matrix(MX_DOMINANT);
         endcase
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule

// ----- sim.f -----
sv/gji_pkg.sv
sv/gji_req_if.sv
sv/gji_rsp_if.sv
sv/gauss_jordan_matrix_inverse_unit.sv
tb/tb.sv
